FILE: hdl/ntfsrl_pkg.sv
// ----------------------------------------------------------------------------
// ntfsrl_pkg
// Shared types and constants of the data-run list decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ntfsrl_pkg;

	localparam int MAX_FIELD_BYTES = 4;

	localparam int CLUSTER_W = 64;
	localparam int BPC_W     = 22;
	localparam int START_W   = 32;
	localparam int BYTES_W   = 63;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(4096);

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_CLUSTER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CLUSTER     = 1'd1;

	localparam logic [7:0] NIB_HI = 8'hF0;
	localparam logic [7:0] NIB_LO = 8'h0F;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_END  = 2'd1,
		ST_SIZE = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	typedef struct packed {
		logic                 valid;
		logic [CLUSTER_W-1:0] off;
		logic [CLUSTER_W-1:0] len;
		logic [CLUSTER_W-1:0] tot;
		status_t              status;
	} run_t;

endpackage

`default_nettype wire

FILE: hdl/ntfsrl_in_if.sv
// ----------------------------------------------------------------------------
// ntfsrl_in_if
// Input channel: one run list byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntfsrl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] run_byte;
	logic       list_start;

	modport source (output valid, output run_byte, output list_start, input ready);
	modport sink (input valid, input run_byte, input list_start, output ready);
endinterface

`default_nettype wire

FILE: hdl/ntfsrl_out_if.sv
// ----------------------------------------------------------------------------
// ntfsrl_out_if
// Result channel: one decoded run or list status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntfsrl_out_if;
	logic                            valid;
	logic                            ready;
	logic [ntfsrl_pkg::BYTES_W-1:0]  run_offset_bytes;
	logic [ntfsrl_pkg::BYTES_W-1:0]  run_length_bytes;
	logic [ntfsrl_pkg::BYTES_W-1:0]  total_bytes;
	ntfsrl_pkg::status_t             status;

	modport source (output valid, output run_offset_bytes, output run_length_bytes,
		output total_bytes, output status, input ready);
	modport sink (input valid, input run_offset_bytes, input run_length_bytes,
		input total_bytes, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/ntfsrl_scale.sv
// ----------------------------------------------------------------------------
// ntfsrl_scale
// Two-stage cluster to byte scaling: split partial products, then sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfsrl_scale (
	input  wire logic                                clk,
	input  wire logic                                en2,
	input  wire logic                                en3,
	input  wire logic [ntfsrl_pkg::CLUSTER_W-1:0]    clusters,
	input  wire logic [ntfsrl_pkg::BPC_W-1:0]        bpc,
	output logic      [ntfsrl_pkg::BYTES_W-1:0]      bytes
);
	localparam int HALF_W = ntfsrl_pkg::CLUSTER_W / 2;
	localparam int PROD_W = HALF_W + ntfsrl_pkg::BPC_W;
	localparam int HI_W   = ntfsrl_pkg::BYTES_W - HALF_W;

	logic [PROD_W-1:0] lo_prod;
	logic [PROD_W-1:0] hi_prod;
	logic [PROD_W-1:0] lo_s2;
	logic [HI_W-1:0]   hi_s2;

	assign lo_prod = PROD_W'(clusters[HALF_W-1:0]) * PROD_W'(bpc);
	assign hi_prod = PROD_W'(clusters[ntfsrl_pkg::CLUSTER_W-1:HALF_W]) * PROD_W'(bpc);

	always_ff @(posedge clk) begin
		if (en2) begin
			lo_s2 <= lo_prod;
			hi_s2 <= hi_prod[HI_W-1:0];
		end
		if (en3) begin
			bytes <= {hi_s2, {HALF_W{1'b0}}} + ntfsrl_pkg::BYTES_W'(lo_s2);
		end
	end
endmodule

`default_nettype wire

FILE: hdl/ntfsrl_decode.sv
// ----------------------------------------------------------------------------
// ntfsrl_decode
// Byte-wise run list parser with cluster accumulator and decode register.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfsrl_decode #(
	parameter int MAX_FIELD_BYTES = ntfsrl_pkg::MAX_FIELD_BYTES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ntfsrl_in_if.sink                              in_ch,
	input  wire logic [ntfsrl_pkg::START_W-1:0]    start_cluster,
	input  wire logic                              en2,
	output ntfsrl_pkg::run_t                       run_s1
);
	localparam int GW = 8 * MAX_FIELD_BYTES;
	localparam int CW = $clog2(MAX_FIELD_BYTES + 1);
	localparam int AW = ntfsrl_pkg::CLUSTER_W;

	typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_OFFSET, PH_WAIT} phase_t;

	phase_t           phase_q, ph, phase_n;
	logic [3:0]       lsize_q, osize_q, lsize_n, osize_n;
	logic [CW-1:0]    cnt_q, cnt_n, cnt_inc;
	logic [GW-1:0]    len_q, off_q, len_n, off_n, len_lane, off_lane;
	logic [AW-1:0]    acc_q, acc_b, acc_n, tot_q, tot_b, tot_n, sext, gz;
	logic             sgn, emit, accept, en1;
	logic [3:0]       lo_nib, hi_nib;
	ntfsrl_pkg::run_t res;

	assign en1 = !run_s1.valid || en2;
	assign in_ch.ready = en1;
	assign accept = in_ch.valid && en1;
	assign cnt_inc = CW'(cnt_q + 1'b1);
	assign lo_nib = 4'(in_ch.run_byte & ntfsrl_pkg::NIB_LO);
	assign hi_nib = 4'((in_ch.run_byte & ntfsrl_pkg::NIB_HI) >> 4);

	always_comb begin
		len_lane = len_q;
		off_lane = off_q;
		for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
			if (cnt_q == CW'(i)) begin
				len_lane[8*i +: 8] = in_ch.run_byte;
				off_lane[8*i +: 8] = in_ch.run_byte;
			end
		end
		sgn = 1'b0;
		for (int n = 1; n <= MAX_FIELD_BYTES; n++) begin
			if (osize_q == 4'(n)) begin
				sgn = off_lane[8*n-1];
			end
		end
		gz = AW'(off_lane);
		for (int k = 0; k < AW; k++) begin
			sext[k] = (k >= 8 * int'(osize_q)) ? sgn : gz[k];
		end
	end

	always_comb begin
		ph = in_ch.list_start ? PH_HEADER : phase_q;
		acc_b = in_ch.list_start ? AW'(start_cluster) : acc_q;
		tot_b = in_ch.list_start ? '0 : tot_q;
		phase_n = ph;
		lsize_n = lsize_q;
		osize_n = osize_q;
		cnt_n = cnt_q;
		len_n = len_q;
		off_n = off_q;
		acc_n = acc_b;
		tot_n = tot_b;
		emit = 1'b0;
		res = '0;
		unique case (ph)
			PH_HEADER: begin
				if (in_ch.run_byte == 8'd0) begin
					phase_n = PH_WAIT;
					emit = 1'b1;
					res.tot = tot_b;
					res.status = ntfsrl_pkg::ST_END;
				end else if (lo_nib == 4'd0 || hi_nib == 4'd0 ||
						32'(lo_nib) > 32'(MAX_FIELD_BYTES) ||
						32'(hi_nib) > 32'(MAX_FIELD_BYTES)) begin
					phase_n = PH_WAIT;
					emit = 1'b1;
					res.status = ntfsrl_pkg::ST_SIZE;
				end else begin
					lsize_n = lo_nib;
					osize_n = hi_nib;
					cnt_n = '0;
					len_n = '0;
					off_n = '0;
					phase_n = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				len_n = len_lane;
				cnt_n = cnt_inc;
				if (cnt_inc >= CW'(lsize_q)) begin
					cnt_n = '0;
					phase_n = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				off_n = off_lane;
				cnt_n = cnt_inc;
				if (cnt_inc >= CW'(osize_q)) begin
					cnt_n = '0;
					emit = 1'b1;
					if (off_lane == '0) begin
						phase_n = PH_WAIT;
						res.status = ntfsrl_pkg::ST_ZERO;
					end else begin
						acc_n = acc_b + sext;
						tot_n = tot_b + AW'(len_q);
						phase_n = PH_HEADER;
						res.off = acc_b + sext;
						res.len = AW'(len_q);
						res.tot = tot_b + AW'(len_q);
						res.status = ntfsrl_pkg::ST_RUN;
					end
				end
			end
			PH_WAIT: begin
			end
		endcase
		res.valid = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lsize_q <= '0;
			osize_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
			off_q <= '0;
			acc_q <= '0;
			tot_q <= '0;
			run_s1 <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				lsize_q <= lsize_n;
				osize_q <= osize_n;
				cnt_q <= cnt_n;
				len_q <= len_n;
				off_q <= off_n;
				acc_q <= acc_n;
				tot_q <= tot_n;
			end
			if (en1) begin
				run_s1.valid <= accept && emit;
			end
			if (accept && emit) begin
				run_s1.off <= res.off;
				run_s1.len <= res.len;
				run_s1.tot <= res.tot;
				run_s1.status <= res.status;
			end
		end
	end
endmodule

`default_nettype wire

FILE: hdl/ntfs_run_list_decoder_unit.sv
// ----------------------------------------------------------------------------
// ntfs_run_list_decoder_unit
// NTFS data-run list decoder with cluster to byte scaling.
// ----------------------------------------------------------------------------
// One run list byte is taken per cycle, every cycle, as long as the result
// side keeps up; header and field bytes that finish nothing give no result.
// The byte that completes a run, a zero header or a bad header yields one
// result. It is registered first in the parser and accumulator register,
// then in the scaling pipeline, where each 64-bit cluster count is split
// into two 32 x 22 partial products that are registered and then summed
// into the output register. Each stage holds its beat while the result
// side stalls, so bubbles are squeezed out and the input keeps flowing
// until all three stages are full.
`default_nettype none

module ntfs_run_list_decoder_unit #(
	parameter int MAX_FIELD_BYTES = ntfsrl_pkg::MAX_FIELD_BYTES
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	ntfsrl_in_if.sink                                 in_ch,
	ntfsrl_out_if.source                              out_ch,
	input  wire logic                                 cfg_we,
	input  wire logic [ntfsrl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ntfsrl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	logic [ntfsrl_pkg::BPC_W-1:0]   bpc_q;
	logic [ntfsrl_pkg::START_W-1:0] start_q;
	ntfsrl_pkg::run_t               run_s1;
	ntfsrl_pkg::status_t            st_s2, st_s3;
	logic                           v2, v3, en2, en3;

	assign en3 = !v3 || out_ch.ready;
	assign en2 = !v2 || en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q <= ntfsrl_pkg::BPC_RESET;
			start_q <= '0;
			v2 <= 1'b0;
			v3 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ntfsrl_pkg::CFG_BYTES_PER_CLUSTER: bpc_q <= cfg_data[ntfsrl_pkg::BPC_W-1:0];
					ntfsrl_pkg::CFG_START_CLUSTER:     start_q <= cfg_data[ntfsrl_pkg::START_W-1:0];
				endcase
			end
			if (en2) begin
				v2 <= run_s1.valid;
			end
			if (en3) begin
				v3 <= v2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			st_s2 <= run_s1.status;
		end
		if (en3) begin
			st_s3 <= st_s2;
		end
	end

	ntfsrl_decode #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.start_cluster (start_q),
		.en2           (en2),
		.run_s1        (run_s1)
	);

	ntfsrl_scale u_scale_off (
		.clk      (clk),
		.en2      (en2),
		.en3      (en3),
		.clusters (run_s1.off),
		.bpc      (bpc_q),
		.bytes    (out_ch.run_offset_bytes)
	);

	ntfsrl_scale u_scale_len (
		.clk      (clk),
		.en2      (en2),
		.en3      (en3),
		.clusters (run_s1.len),
		.bpc      (bpc_q),
		.bytes    (out_ch.run_length_bytes)
	);

	ntfsrl_scale u_scale_tot (
		.clk      (clk),
		.en2      (en2),
		.en3      (en3),
		.clusters (run_s1.tot),
		.bpc      (bpc_q),
		.bytes    (out_ch.total_bytes)
	);

	assign out_ch.valid = v3;
	assign out_ch.status = st_s3;

`ifndef SYNTH
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ntfsrl_pkg::ST_END) |->
		(out_ch.run_offset_bytes == '0 && out_ch.run_length_bytes == '0))
		else $error("end of list beat carries run fields");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status == ntfsrl_pkg::ST_SIZE ||
		out_ch.status == ntfsrl_pkg::ST_ZERO)) |->
		(out_ch.run_offset_bytes == '0 && out_ch.run_length_bytes == '0 &&
		out_ch.total_bytes == '0))
		else $error("error beat carries nonzero fields");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!run_s1.valid && !v2 && !v3) |-> in_ch.ready)
		else $error("input stalled with empty pipeline");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (run_s1.valid && v2 && v3 && !out_ch.ready))
		else $error("input stalled without full pipeline and downstream stall");
`endif
endmodule

`default_nettype wire

FILE: tb/tb_ntfs_run_list_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntfs_run_list_decoder_unit
// Self-checking bench for the data-run list decoder.
// ----------------------------------------------------------------------------
// A short table of hand-written bytes comes first: end of list right after
// reset, widest fields with a negative offset, bad headers, a zero offset and
// ignored bytes. Random run lists follow under several cluster sizes and
// start clusters, with broken lists and noise mixed in. A bit-level decoder
// in the bench predicts each result; both channels idle and stall at random.
module tb_ntfs_run_list_decoder_unit;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int BYTES_PER_PASS = 88;

	typedef enum logic [1:0] {
		P_HEADER,
		P_LENGTH,
		P_OFFSET,
		P_WAIT
	} parse_state_t;

	typedef struct packed {
		logic [ntfsrl_pkg::BYTES_W-1:0] off;
		logic [ntfsrl_pkg::BYTES_W-1:0] len;
		logic [ntfsrl_pkg::BYTES_W-1:0] tot;
		ntfsrl_pkg::status_t            status;
	} decoded_run_t;

	typedef struct packed {
		logic [7:0]   run_byte;
		logic         first;
		logic         typed;
		decoded_run_t want;
	} beat_row_t;

	localparam beat_row_t DIRECTED [23] = '{
		'{8'h00, 1'b1, 1'b1, '{63'd0, 63'd0, 63'd0, ntfsrl_pkg::ST_END}},
		'{8'h11, 1'b1, 1'b0, '0},
		'{8'h05, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h44, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h37, 1'b1, 1'b1, '{63'd0, 63'd0, 63'd0, ntfsrl_pkg::ST_SIZE}},
		'{8'h55, 1'b1, 1'b1, '{63'd0, 63'd0, 63'd0, ntfsrl_pkg::ST_SIZE}},
		'{8'h10, 1'b1, 1'b1, '{63'd0, 63'd0, 63'd0, ntfsrl_pkg::ST_SIZE}},
		'{8'hF1, 1'b1, 1'b1, '{63'd0, 63'd0, 63'd0, ntfsrl_pkg::ST_SIZE}},
		'{8'h12, 1'b1, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{63'd0, 63'd0, 63'd0, ntfsrl_pkg::ST_ZERO}},
		'{8'h33, 1'b0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ntfsrl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ntfsrl_pkg::CFG_DATA_W-1:0] cfg_data;

	ntfsrl_in_if  in_ch();
	ntfsrl_out_if out_ch();

	// decoder state of the bench
	logic [ntfsrl_pkg::BPC_W-1:0]     bpc;
	logic [ntfsrl_pkg::START_W-1:0]   start_clus;
	parse_state_t                     parse_st;
	logic [3:0]                       len_size;
	logic [3:0]                       off_size;
	logic [3:0]                       nbytes;
	logic [ntfsrl_pkg::CLUSTER_W-1:0] len_gather;
	logic [ntfsrl_pkg::CLUSTER_W-1:0] off_gather;
	logic [ntfsrl_pkg::CLUSTER_W-1:0] clus_acc;
	logic [ntfsrl_pkg::CLUSTER_W-1:0] clus_total;

	decoded_run_t runs_due[$];
	int fails = 0;
	int bytes_taken = 0;
	int quiet = 0;
	bit no_idle = 1'b0;
	bit stall_long = 1'b0;

	ntfs_run_list_decoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [ntfsrl_pkg::BYTES_W-1:0] to_bytes(
		input logic [ntfsrl_pkg::CLUSTER_W-1:0] clusters);
		logic [ntfsrl_pkg::CLUSTER_W-1:0] prod;
		prod = clusters * {{(ntfsrl_pkg::CLUSTER_W-ntfsrl_pkg::BPC_W){1'b0}}, bpc};
		return prod[ntfsrl_pkg::BYTES_W-1:0];
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic first,
		output decoded_run_t r);
		logic signed [ntfsrl_pkg::CLUSTER_W-1:0] rel;
		int sh;
		r = '0;
		if (first) begin
			clus_acc = {{(ntfsrl_pkg::CLUSTER_W-ntfsrl_pkg::START_W){1'b0}}, start_clus};
			clus_total = '0;
			parse_st = P_HEADER;
		end
		case (parse_st)
			P_HEADER: begin
				if (b == 8'd0) begin
					parse_st = P_WAIT;
					r.tot = to_bytes(clus_total);
					r.status = ntfsrl_pkg::ST_END;
					return 1'b1;
				end
				len_size = 4'(b & ntfsrl_pkg::NIB_LO);
				off_size = 4'((b & ntfsrl_pkg::NIB_HI) >> 4);
				if (len_size == 0 || off_size == 0 ||
					len_size > ntfsrl_pkg::MAX_FIELD_BYTES ||
					off_size > ntfsrl_pkg::MAX_FIELD_BYTES) begin
					parse_st = P_WAIT;
					r.status = ntfsrl_pkg::ST_SIZE;
					return 1'b1;
				end
				nbytes = '0;
				len_gather = '0;
				off_gather = '0;
				parse_st = P_LENGTH;
			end
			P_LENGTH: begin
				len_gather |= ntfsrl_pkg::CLUSTER_W'(b) << (8 * nbytes);
				nbytes++;
				if (nbytes >= len_size) begin
					nbytes = '0;
					parse_st = P_OFFSET;
				end
			end
			P_OFFSET: begin
				off_gather |= ntfsrl_pkg::CLUSTER_W'(b) << (8 * nbytes);
				nbytes++;
				if (nbytes >= off_size) begin
					nbytes = '0;
					sh = ntfsrl_pkg::CLUSTER_W - 8 * off_size;
					rel = $signed(off_gather << sh) >>> sh;
					if (rel == 0) begin
						parse_st = P_WAIT;
						r.status = ntfsrl_pkg::ST_ZERO;
						return 1'b1;
					end
					clus_acc += rel;
					clus_total += len_gather;
					parse_st = P_HEADER;
					r.off = to_bytes(clus_acc);
					r.len = to_bytes(len_gather);
					r.tot = to_bytes(clus_total);
					r.status = ntfsrl_pkg::ST_RUN;
					return 1'b1;
				end
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic first,
		input logic typed = 1'b0, input decoded_run_t typed_run = '0);
		int gap;
		bit live;
		decoded_run_t r;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.run_byte <= b;
		in_ch.list_start <= first;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		live = first || parse_st != P_WAIT;
		if (decode_byte(b, first, r))
			runs_due = {runs_due, (typed ? typed_run : r)};
		if (live)
			bytes_taken++;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// one list: mostly well-formed runs, sometimes cut short or broken
	task automatic gen_list();
		int nruns;
		int r;
		int ls;
		int os;
		logic [7:0] hdr;
		nruns = $urandom_range(1, 5);
		for (int k = 0; k < nruns; k++) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				do
					hdr = 8'($urandom_range(1, 255));
				while (hdr[3:0] >= 1 && hdr[3:0] <= ntfsrl_pkg::MAX_FIELD_BYTES &&
					hdr[7:4] >= 1 && hdr[7:4] <= ntfsrl_pkg::MAX_FIELD_BYTES);
				send_beat(hdr, k == 0);
				send_noise();
				return;
			end
			ls = $urandom_range(1, ntfsrl_pkg::MAX_FIELD_BYTES);
			os = $urandom_range(1, ntfsrl_pkg::MAX_FIELD_BYTES);
			send_beat({4'(os), 4'(ls)}, k == 0);
			repeat (ls) send_beat(8'($urandom_range(0, 255)), 1'b0);
			if (r < 10) begin
				repeat (os) send_beat(8'h00, 1'b0);
				send_noise();
				return;
			end
			if (r < 15) begin
				// next list start drops this partial run
				repeat ($urandom_range(0, os - 1)) send_beat(8'($urandom_range(0, 255)), 1'b0);
				return;
			end
			repeat (os) send_beat(8'($urandom_range(0, 255)), 1'b0);
		end
		if ($urandom_range(0, 9) != 0) begin
			send_beat(8'h00, 1'b0);
			send_noise();
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (runs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ntfsrl_pkg::CFG_IDX_W-1:0] idx,
		input logic [ntfsrl_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == ntfsrl_pkg::CFG_BYTES_PER_CLUSTER)
			bpc = data[ntfsrl_pkg::BPC_W-1:0];
		else
			start_clus = data;
	endtask

	task automatic check_run();
		decoded_run_t want;
		if (runs_due.size() == 0) begin
			$error("unexpected result beat: status %0d", out_ch.status);
			fails++;
			return;
		end
		want = runs_due.pop_front();
		if (out_ch.run_offset_bytes !== want.off) begin
			$error("run_offset_bytes: expected %h, got %h", want.off, out_ch.run_offset_bytes);
			fails++;
		end
		if (out_ch.run_length_bytes !== want.len) begin
			$error("run_length_bytes: expected %h, got %h", want.len, out_ch.run_length_bytes);
			fails++;
		end
		if (out_ch.total_bytes !== want.tot) begin
			$error("total_bytes: expected %h, got %h", want.tot, out_ch.total_bytes);
			fails++;
		end
		if (out_ch.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, out_ch.status);
			fails++;
		end
	endtask

	initial begin : result_sink
		int n;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_long) begin
				stall_long = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					out_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			check_run();
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : byte_source
		int goal;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.run_byte = '0;
		in_ch.list_start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bpc = ntfsrl_pkg::BPC_RESET;
		start_clus = '0;
		parse_st = P_HEADER;
		len_size = '0;
		off_size = '0;
		nbytes = '0;
		len_gather = '0;
		off_gather = '0;
		clus_acc = '0;
		clus_total = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIRECTED); i++)
			send_beat(DIRECTED[i].run_byte, DIRECTED[i].first, DIRECTED[i].typed,
				DIRECTED[i].want);
		settle();

		for (int pass = 0; pass < 5; pass++) begin
			case (pass)
				0: begin
					write_reg(ntfsrl_pkg::CFG_BYTES_PER_CLUSTER, 32'd512);
					write_reg(ntfsrl_pkg::CFG_START_CLUSTER, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(ntfsrl_pkg::CFG_BYTES_PER_CLUSTER, 32'd2097152);
					write_reg(ntfsrl_pkg::CFG_START_CLUSTER, $urandom());
				end
				2: begin
					write_reg(ntfsrl_pkg::CFG_BYTES_PER_CLUSTER, 32'd0);
					write_reg(ntfsrl_pkg::CFG_START_CLUSTER, 32'd0);
				end
				3: begin
					write_reg(ntfsrl_pkg::CFG_BYTES_PER_CLUSTER, 32'hFFFF_FFFF);
					write_reg(ntfsrl_pkg::CFG_START_CLUSTER, 32'h8000_0000);
				end
				default: begin
					write_reg(ntfsrl_pkg::CFG_BYTES_PER_CLUSTER, 32'hFFC0_0001);
					write_reg(ntfsrl_pkg::CFG_START_CLUSTER, $urandom());
				end
			endcase
			goal = bytes_taken + BYTES_PER_PASS;
			if (pass == 1) begin
				// result side holds off while bytes keep streaming in
				no_idle = 1'b1;
				stall_long = 1'b1;
				repeat (4) gen_list();
			end
			while (bytes_taken < goal) begin
				no_idle = ($urandom_range(0, 5) == 0);
				gen_list();
			end
			no_idle = 1'b0;
			settle();
		end

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
hdl/ntfsrl_pkg.sv
hdl/ntfsrl_in_if.sv
hdl/ntfsrl_out_if.sv
hdl/ntfsrl_scale.sv
hdl/ntfsrl_decode.sv
hdl/ntfs_run_list_decoder_unit.sv
tb/tb_ntfs_run_list_decoder_unit.sv
